// File: rtl/sfb_pkg.sv
// package for the sensor frame builder: frame geometry, queue sizing,
// shared item and configuration types, and the crc-8 byte update
// no dependencies
package sfb_pkg;

  // frame geometry, length held to the range 2..127 words
  localparam int WordsPerFrame = 15;
  localparam int FRAME_WORDS   = (WordsPerFrame < 2)   ? 2 :
                                 (WordsPerFrame > 127) ? 127 : WordsPerFrame;
  localparam int POS_W         = $clog2(FRAME_WORDS);

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_FIRST      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_SECOND     = 3'd5;

  localparam logic [7:0] PAYLOAD_LENGTH_RST = 8'd30;

  // crc-8, poly 0x07, init 0, msb first
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // one classified word in flight between front and back
  typedef struct packed {
    logic [15:0] sample_word;
    logic        first;
    logic        last;
  } sfb_item_t;

  // framing bytes
  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] frame_type;
    logic [7:0] payload_length;
    logic [7:0] end_first;
    logic [7:0] end_second;
  } sfb_cfg_t;

  // one byte through the crc, bit by bit
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/sfb_if.sv
// valid/ready channel interfaces: sensor words in, frame bytes out
// depends on nothing
interface sfb_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink   (input valid, input sample_word, output ready);
endinterface

interface sfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// File: rtl/sensor_frame_builder_crc8.sv
// sensor frame builder with crc-8: one 16-bit word in, framed bytes out.
// the queue and the output register lie between a word and its first byte.
// throughput: one byte per cycle out of the back-end sequencer while a word is queued
// and not stalled, so a word yields 6 bytes at frame start, 5 at frame end, 2 otherwise (37 per 15).
// reset: asynchronous active low; clears the queue, sequencer, crc and word
// position, and loads the framing registers with their defaults.
module sensor_frame_builder_crc8
  import sfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sfb_word_if.sink             word_in,
  sfb_byte_if.source           byte_out,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  sfb_cfg_t  cfg_q;
  sfb_item_t push_item, head_item;
  logic      push, full, head_valid, pop;

  // framing registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first    <= 8'h00;
      cfg_q.start_second   <= 8'h00;
      cfg_q.frame_type     <= 8'h00;
      cfg_q.payload_length <= PAYLOAD_LENGTH_RST;
      cfg_q.end_first      <= 8'h00;
      cfg_q.end_second     <= 8'h00;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_FIRST:    cfg_q.start_first    <= cfg_data_i;
        REG_START_SECOND:   cfg_q.start_second   <= cfg_data_i;
        REG_FRAME_TYPE:     cfg_q.frame_type     <= cfg_data_i;
        REG_PAYLOAD_LENGTH: cfg_q.payload_length <= cfg_data_i;
        REG_END_FIRST:      cfg_q.end_first      <= cfg_data_i;
        REG_END_SECOND:     cfg_q.end_second     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // word intake and classification
  sfb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .word_in (word_in),
    .full_i  (full),
    .push_o  (push),
    .item_o  (push_item)
  );

  // decoupling queue
  sfb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_item)
  );

  // byte sequencer
  sfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .byte_out     (byte_out)
  );

endmodule

// File: rtl/sfb_front.sv
// front end: accepts sensor words and tags the first and last word of a frame
// depends on sfb_pkg and sfb_word_if
module sfb_front
  import sfb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  sfb_word_if.sink          word_in,
  input  logic              full_i,
  output logic              push_o,
  output sfb_item_t         item_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             is_last;

  // classify against the word position in the frame
  assign is_last             = (pos_q == POS_W'(FRAME_WORDS - 1));
  assign word_in.ready       = !full_i;
  assign push_o              = word_in.valid && !full_i;
  assign item_o.sample_word  = word_in.sample_word;
  assign item_o.first        = (pos_q == '0);
  assign item_o.last         = is_last;

  // position counter, wraps after the last word
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = is_last ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: rtl/sfb_fifo.sv
// short queue of classified words between the front and back ends
// depends on sfb_pkg
module sfb_fifo
  import sfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sfb_item_t  item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output sfb_item_t  head_o
);

  sfb_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/sfb_back.sv
// back end: byte sequencer with running crc-8 and registered output
// depends on sfb_pkg and sfb_byte_if
module sfb_back
  import sfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  sfb_item_t  head_i,
  output logic       pop_o,
  input  sfb_cfg_t   cfg_i,
  sfb_byte_if.source byte_out
);

  // sequencer phases
  localparam logic [3:0] P_HEAD   = 4'd0;
  localparam logic [3:0] P_START2 = 4'd1;
  localparam logic [3:0] P_TYPE   = 4'd2;
  localparam logic [3:0] P_LEN    = 4'd3;
  localparam logic [3:0] P_HI     = 4'd4;
  localparam logic [3:0] P_LO     = 4'd5;
  localparam logic [3:0] P_CRC    = 4'd6;
  localparam logic [3:0] P_END1   = 4'd7;
  localparam logic [3:0] P_END2   = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] byte_q, byte_d;
  logic       end_q, end_d;
  logic       out_valid_q;
  logic       adv, pop;
  logic [7:0] hi_byte, lo_byte;

  assign hi_byte = head_i.sample_word[15:8];
  assign lo_byte = head_i.sample_word[7:0];

  // advance one byte whenever a word is queued and the output slot is free
  assign adv   = head_valid_i && (!out_valid_q || byte_out.ready);
  assign pop_o = adv && pop;

  // next byte, next phase and crc update
  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    byte_d  = 8'h00;
    end_d   = 1'b0;
    pop     = 1'b0;
    case (phase_q)
      P_HEAD: begin
        if (head_i.first) begin
          byte_d  = cfg_i.start_first;
          phase_d = P_START2;
        end else begin
          byte_d  = hi_byte;
          crc_d   = crc8_byte(crc_q, hi_byte);
          phase_d = P_LO;
        end
      end
      P_START2: begin
        byte_d  = cfg_i.start_second;
        phase_d = P_TYPE;
      end
      P_TYPE: begin
        byte_d  = cfg_i.frame_type;
        crc_d   = crc8_byte(CRC_INIT, cfg_i.frame_type);
        phase_d = P_LEN;
      end
      P_LEN: begin
        byte_d  = cfg_i.payload_length;
        crc_d   = crc8_byte(crc_q, cfg_i.payload_length);
        phase_d = P_HI;
      end
      P_HI: begin
        byte_d  = hi_byte;
        crc_d   = crc8_byte(crc_q, hi_byte);
        phase_d = P_LO;
      end
      P_LO: begin
        byte_d = lo_byte;
        crc_d  = crc8_byte(crc_q, lo_byte);
        if (head_i.last) begin
          phase_d = P_CRC;
        end else begin
          phase_d = P_HEAD;
          pop     = 1'b1;
        end
      end
      P_CRC: begin
        byte_d  = crc_q;
        phase_d = P_END1;
      end
      P_END1: begin
        byte_d  = cfg_i.end_first;
        phase_d = P_END2;
      end
      P_END2: begin
        byte_d  = cfg_i.end_second;
        end_d   = 1'b1;
        crc_d   = CRC_INIT;
        phase_d = P_HEAD;
        pop     = 1'b1;
      end
      default: begin
        phase_d = P_HEAD;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_HEAD;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q     <= phase_d;
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (byte_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      end_q  <= end_d;
    end
  end

  assign byte_out.valid     = out_valid_q;
  assign byte_out.out_byte  = byte_q;
  assign byte_out.frame_end = end_q;

endmodule

// File: tb/sv/sfb_frame_checker.sv
// frame checker for the sensor frame builder: watches the word, byte and register ports,
// predicts every frame byte and compares it with what the block sends
// depends on sfb_pkg and the channel interfaces in sfb_if.sv
`timescale 1ns / 100ps

module sfb_frame_checker
  import sfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sfb_word_if                  word_mon,
  sfb_byte_if                  byte_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   bytes_checked_o
);

  localparam logic [7:0] CrcPoly = 8'h07;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } frame_byte_t;

  // bytes still owed by the block, oldest first
  frame_byte_t expected_bytes [$];
  frame_byte_t head_byte;

  // shadow of the framing registers and of the frame progress
  sfb_cfg_t   regs_shadow;
  logic [6:0] word_pos;
  logic [7:0] crc_acc;

  // crc-8 over one byte, one data bit at a time from the top
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  // expand one accepted sensor word into the frame bytes it owes
  task automatic frame_word(input logic [15:0] w);
    if (word_pos == 0) begin
      crc_acc = 8'h00;
      expected_bytes.push_back('{regs_shadow.start_first, 1'b0});
      expected_bytes.push_back('{regs_shadow.start_second, 1'b0});
      expected_bytes.push_back('{regs_shadow.frame_type, 1'b0});
      crc_acc = crc8_update(crc_acc, regs_shadow.frame_type);
      expected_bytes.push_back('{regs_shadow.payload_length, 1'b0});
      crc_acc = crc8_update(crc_acc, regs_shadow.payload_length);
    end
    expected_bytes.push_back('{w[15:8], 1'b0});
    crc_acc = crc8_update(crc_acc, w[15:8]);
    expected_bytes.push_back('{w[7:0], 1'b0});
    crc_acc = crc8_update(crc_acc, w[7:0]);
    if (int'(word_pos) + 1 >= FRAME_WORDS) begin
      expected_bytes.push_back('{crc_acc, 1'b0});
      expected_bytes.push_back('{regs_shadow.end_first, 1'b0});
      expected_bytes.push_back('{regs_shadow.end_second, 1'b1});
      word_pos = '0;
      crc_acc  = 8'h00;
    end else begin
      word_pos = word_pos + 7'd1;
    end
  endtask

  // sample all three ports on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes.delete();
      word_pos                   = '0;
      crc_acc                    = 8'h00;
      regs_shadow                = '0;
      regs_shadow.payload_length = PAYLOAD_LENGTH_RST;
    end else begin
      // input transaction
      if (word_mon.valid && word_mon.ready) begin
        frame_word(word_mon.sample_word);
      end

      // output transaction against the oldest expectation
      if (byte_mon.valid && byte_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected no transaction, got 8'h%02h (frame_end %0b)",
                 byte_mon.out_byte, byte_mon.frame_end);
          fail_count_o++;
        end else begin
          head_byte = expected_bytes.pop_front();
          if (byte_mon.out_byte !== head_byte.out_byte) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h",
                   head_byte.out_byte, byte_mon.out_byte);
            fail_count_o++;
          end
          if (byte_mon.frame_end !== head_byte.frame_end) begin
            $error("frame_end: expected %0b, got %0b",
                   head_byte.frame_end, byte_mon.frame_end);
            fail_count_o++;
          end
          bytes_checked_o++;
        end
      end

      // register writes, unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_START_FIRST:    regs_shadow.start_first    = cfg_data_i;
          REG_START_SECOND:   regs_shadow.start_second   = cfg_data_i;
          REG_FRAME_TYPE:     regs_shadow.frame_type     = cfg_data_i;
          REG_PAYLOAD_LENGTH: regs_shadow.payload_length = cfg_data_i;
          REG_END_FIRST:      regs_shadow.end_first      = cfg_data_i;
          REG_END_SECOND:     regs_shadow.end_second     = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

// File: tb/sv/sensor_frame_builder_crc8_tb.sv
// top of the sensor frame builder testbench: clock, reset, word and register stimulus,
// output back-pressure and the verdict; checking lives in sfb_frame_checker
// depends on sfb_pkg, sfb_if.sv, sfb_frame_checker.sv and the block itself
`timescale 1ns / 100ps

module sensor_frame_builder_crc8_tb;
  import sfb_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 16;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // field extremes and walking patterns for the opening frames
  localparam logic [15:0] CornerWords [15] = '{
    16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h00FF,
    16'hFF00, 16'h5555, 16'hAAAA, 16'h7FFF, 16'hFFFE,
    16'h0080, 16'h0100, 16'h1234, 16'hEDCB, 16'h8001
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   words_sent    = 0;
  int   settings_used = 0;
  int   cycle_count   = 0;
  logic hold_active;
  event hold_off_ev;

  int fail_count;
  int pending_bytes;
  int bytes_checked;

  sfb_word_if word_if ();
  sfb_byte_if byte_if ();

  sensor_frame_builder_crc8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_in     (word_if),
    .byte_out    (byte_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sfb_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .word_mon        (word_if),
    .byte_mon        (byte_if),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending_bytes),
    .bytes_checked_o (bytes_checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sensor_frame_builder_crc8 verification failed");
    $finish;
  end

  // long output hold, counted on its own
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_off_ev);
      @(posedge clk_i);
      hold_active = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_active = 1'b0;
    end
  end

  // receiver: random stalls plus the long hold
  initial begin
    byte_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      byte_if.ready <= !hold_active && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic sfb_cfg_t random_cfg();
    sfb_cfg_t c;
    c.start_first    = pick_byte();
    c.start_second   = pick_byte();
    c.frame_type     = pick_byte();
    c.payload_length = pick_byte();
    c.end_first      = pick_byte();
    c.end_second     = pick_byte();
    return c;
  endfunction

  function automatic logic [15:0] next_sample();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  // one register write, enable is lowered by the caller
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk_i);
  endtask

  // all framing registers, then writes to the unused indexes
  task automatic program_regs(input sfb_cfg_t c);
    write_reg(REG_START_FIRST, c.start_first);
    write_reg(REG_START_SECOND, c.start_second);
    write_reg(REG_FRAME_TYPE, c.frame_type);
    write_reg(REG_PAYLOAD_LENGTH, c.payload_length);
    write_reg(REG_END_FIRST, c.end_first);
    write_reg(REG_END_SECOND, c.end_second);
    write_reg(REG_UNUSED_LO, 8'($urandom));
    write_reg(REG_UNUSED_HI, 8'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // offer one word after random idle cycles, return at the next falling edge
  task automatic send_word(input logic [15:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      word_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    word_if.valid       <= 1'b1;
    word_if.sample_word <= w;
    do @(posedge clk_i); while (!word_if.ready);
    words_sent++;
    @(negedge clk_i);
  endtask

  // stop offering and wait for every owed byte
  task automatic settle();
    word_if.valid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input int n_words, input int src_pct, input int snk_pct);
    settle();
    program_regs(random_cfg());
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    repeat (n_words) send_word(next_sample());
  endtask

  // stimulus
  initial begin
    sfb_cfg_t all_ones;

    word_if.valid       = 1'b0;
    word_if.sample_word = 16'h0000;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = 8'h00;
    rst_ni              = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // one whole frame on the reset register values
    for (int i = 0; i < 15; i++) send_word(CornerWords[i]);

    // every framing byte at its top value, then a frame left open
    settle();
    all_ones = '1;
    program_regs(all_ones);
    for (int i = 0; i < 8; i++) send_word(CornerWords[14 - i]);

    // random phases, each starting with new registers, often mid-frame
    run_phase(110, 0, 0);
    run_phase(110, 59, 0);
    run_phase(110, 0, 59);
    run_phase(110, 13, 13);

    // back-pressure: output held while words keep coming
    settle();
    program_regs(random_cfg());
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    -> hold_off_ev;
    repeat (40) send_word(next_sample());

    settle();
    repeat (TailCycles) @(negedge clk_i);

    $display("covered %0d sensor words, %0d frame bytes checked, %0d register settings",
             words_sent, bytes_checked, settings_used);
    $display("with sender gaps, receiver stalls, a %0d-cycle output hold, open frames",
             HoldCycles);
    if (fail_count == 0) begin
      $display("sensor_frame_builder_crc8 verification clean");
    end else begin
      $display("sensor_frame_builder_crc8 verification failed");
    end
    $finish;
  end

endmodule
